/* rtl/core/sti_pkg.sv */
package sti_pkg;

  // Coordinate width inside the datapath; fields and registers are 32 bits wide.
  localparam int COORD_WIDTH = 32;
  localparam int CW = COORD_WIDTH;
  localparam int FW = 32;

  // Dot products for the plane solve.
  localparam int DW  = CW + 1;        // coordinate difference
  localparam int PPW = CW + DW;       // n * difference
  localparam int PW  = PPW + 2;       // sum of three products

  // Quantized t and the restoring divider.
  localparam int TFRAC = 16;
  localparam int QW    = TFRAC + 1;
  localparam int RW    = PW + 1;

  // Hit point and edge tests.
  localparam int HPW = DW + QW + 1;   // d * t product
  localparam int HW  = CW + 1;        // hit point
  localparam int VW  = CW + 2;        // hit point minus vertex
  localparam int MW  = DW + VW;       // cross product term
  localparam int XW  = MW + 1;        // cross product component
  localparam int LW  = CW + 2;        // low slice of a cross component
  localparam int PLW = CW + LW + 1;
  localparam int PHW = CW + XW - LW;
  localparam int TW  = CW + XW;
  localparam int SW  = TW + 2;

  // Squared distance and root.
  localparam int SQW      = 2 * DW;
  localparam int DSW      = SQW + 2;
  localparam int RTW      = 64;
  localparam int SQ_STEPS = RTW / 2;

  // Queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FPW        = $clog2(FIFO_DEPTH);

  // Register map.
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_SEG_START_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SEG_START_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SEG_START_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SEG_END_X   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SEG_END_Y   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SEG_END_Z   = 3'd5;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [HW-1:0] hpt_t;
  typedef logic [PW-1:0] mag_t;

  // Classified triangle, front to back.
  typedef struct {
    logic cand;
    mag_t an;
    mag_t ad;
    crd_t a [3];
    crd_t b [3];
    crd_t c [3];
    crd_t n [3];
  } tri_t;

  // Geometry result, back to root stage.
  typedef struct {
    logic                  hit;
    hpt_t                  h [3];
    logic signed [DSW-1:0] dsq;
  } fin_t;

  // Low CW bits of a field, read as a signed coordinate.
  function automatic crd_t coord(input logic [FW-1:0] f);
    logic [CW+FW-1:0] ext;
    ext = (CW + FW)'(f);
    return ext[CW-1:0];
  endfunction

  // Sign-extend a hit coordinate and keep the low field bits.
  function automatic logic [FW-1:0] to_field(input hpt_t v);
    logic signed [HW+FW-1:0] ext;
    ext = (HW + FW)'(v);
    return ext[FW-1:0];
  endfunction

endpackage

/* rtl/core/sti_front.sv */
module sti_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [sti_pkg::FW-1:0] vertex_a_x,
  input  logic [sti_pkg::FW-1:0] vertex_a_y,
  input  logic [sti_pkg::FW-1:0] vertex_a_z,
  input  logic [sti_pkg::FW-1:0] vertex_b_x,
  input  logic [sti_pkg::FW-1:0] vertex_b_y,
  input  logic [sti_pkg::FW-1:0] vertex_b_z,
  input  logic [sti_pkg::FW-1:0] vertex_c_x,
  input  logic [sti_pkg::FW-1:0] vertex_c_y,
  input  logic [sti_pkg::FW-1:0] vertex_c_z,
  input  logic [sti_pkg::FW-1:0] plane_nx,
  input  logic [sti_pkg::FW-1:0] plane_ny,
  input  logic [sti_pkg::FW-1:0] plane_nz,
  input  sti_pkg::crd_t          seg_s [3],
  input  sti_pkg::crd_t          seg_e [3],
  output logic                   push,
  output sti_pkg::tri_t          push_data,
  input  logic                   full
);
  import sti_pkg::*;

  logic adv;
  logic v1, v2, v3, v4;

  crd_t ai [3];
  crd_t bi [3];
  crd_t ci [3];
  crd_t ni [3];

  crd_t a1 [3];
  crd_t b1 [3];
  crd_t c1 [3];
  crd_t n1 [3];
  dif_t as1 [3];
  dif_t d1 [3];

  crd_t a2 [3];
  crd_t b2 [3];
  crd_t c2 [3];
  crd_t n2 [3];
  logic signed [PPW-1:0] pn2 [3];
  logic signed [PPW-1:0] pd2 [3];

  crd_t a3 [3];
  crd_t b3 [3];
  crd_t c3 [3];
  crd_t n3 [3];
  logic signed [PW-1:0] num3;
  logic signed [PW-1:0] den3;

  logic cand3;
  mag_t an3;
  mag_t ad3;
  tri_t t4;

  assign ai[0] = coord(vertex_a_x);
  assign ai[1] = coord(vertex_a_y);
  assign ai[2] = coord(vertex_a_z);
  assign bi[0] = coord(vertex_b_x);
  assign bi[1] = coord(vertex_b_y);
  assign bi[2] = coord(vertex_b_z);
  assign ci[0] = coord(vertex_c_x);
  assign ci[1] = coord(vertex_c_y);
  assign ci[2] = coord(vertex_c_z);
  assign ni[0] = coord(plane_nx);
  assign ni[1] = coord(plane_ny);
  assign ni[2] = coord(plane_nz);

  // Hold everything while the last stage waits on a full queue.
  assign adv       = !(v4 && full);
  assign in_stall  = rst || !adv;
  assign push      = v4 && !full;
  assign push_data = t4;

  // Accept t in [0,1]: num and den share a sign and |num| <= |den|.
  always_comb begin
    if (den3 == '0) begin
      cand3 = 1'b0;
    end else if (den3[PW-1]) begin
      cand3 = (den3 <= num3) && (num3[PW-1] || (num3 == '0));
    end else begin
      cand3 = !num3[PW-1] && (num3 <= den3);
    end
    an3 = num3[PW-1] ? mag_t'(-num3) : mag_t'(num3);
    ad3 = den3[PW-1] ? mag_t'(-den3) : mag_t'(den3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a1[i]  <= ai[i];
        b1[i]  <= bi[i];
        c1[i]  <= ci[i];
        n1[i]  <= ni[i];
        as1[i] <= DW'(ai[i]) - DW'(seg_s[i]);
        d1[i]  <= DW'(seg_e[i]) - DW'(seg_s[i]);

        a2[i]  <= a1[i];
        b2[i]  <= b1[i];
        c2[i]  <= c1[i];
        n2[i]  <= n1[i];
        pn2[i] <= n1[i] * as1[i];
        pd2[i] <= n1[i] * d1[i];

        a3[i]  <= a2[i];
        b3[i]  <= b2[i];
        c3[i]  <= c2[i];
        n3[i]  <= n2[i];
      end
      num3 <= PW'(pn2[0]) + PW'(pn2[1]) + PW'(pn2[2]);
      den3 <= PW'(pd2[0]) + PW'(pd2[1]) + PW'(pd2[2]);

      t4.cand <= cand3;
      t4.an   <= an3;
      t4.ad   <= ad3;
      t4.a    <= a3;
      t4.b    <= b3;
      t4.c    <= c3;
      t4.n    <= n3;
    end
  end

endmodule

/* rtl/core/sti_fifo.sv */
module sti_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sti_pkg::tri_t push_data,
  output logic          full,
  input  logic          pop,
  output sti_pkg::tri_t head,
  output logic          empty
);
  import sti_pkg::*;

  tri_t            mem [FIFO_DEPTH];
  logic [FPW-1:0]  wr_ptr;
  logic [FPW-1:0]  rd_ptr;
  logic [FPW:0]    count;
  logic [FPW:0]    count_next;

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (FPW + 1)'(FIFO_DEPTH));

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

/* rtl/core/sti_back.sv */
module sti_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          empty,
  input  sti_pkg::tri_t head,
  output logic          pop,
  input  sti_pkg::crd_t seg_s [3],
  input  sti_pkg::crd_t seg_e [3],
  output logic          fin_valid,
  output sti_pkg::fin_t fin
);
  import sti_pkg::*;

  // Divider stages: one quotient bit per stage.
  logic           dvv   [QW+1];
  logic           dcand [QW+1];
  logic [RW-1:0]  drem  [QW+1];
  mag_t           dad   [QW+1];
  logic [QW-1:0]  dq    [QW+1];
  crd_t           da    [QW+1][3];
  crd_t           db    [QW+1][3];
  crd_t           dc    [QW+1][3];
  crd_t           dn    [QW+1][3];
  logic           dge   [QW];

  dif_t                  dseg [3];
  logic signed [QW:0]    qs;

  logic                  vld_h1, h1_cand;
  logic signed [HPW-1:0] h1_prod [3];
  crd_t h1_a [3];
  crd_t h1_b [3];
  crd_t h1_c [3];
  crd_t h1_n [3];
  dif_t                  ddc [3];

  logic vld_h2, h2_cand;
  dif_t h2_dd [3];
  hpt_t h2_h [3];
  crd_t h2_a [3];
  crd_t h2_b [3];
  crd_t h2_c [3];
  crd_t h2_n [3];

  logic                  vld_e1, e1_cand;
  dif_t                  e1_e [3][3];
  logic signed [VW-1:0]  e1_v [3][3];
  logic signed [SQW-1:0] e1_sq [3];
  hpt_t                  e1_h [3];
  crd_t                  e1_n [3];

  logic                  vld_e2, e2_cand;
  logic signed [MW-1:0]  e2_m [3][6];
  logic signed [DSW-1:0] e2_dsq;
  hpt_t                  e2_h [3];
  crd_t                  e2_n [3];

  logic                  vld_e3, e3_cand;
  logic signed [XW-1:0]  e3_c [3][3];
  logic signed [DSW-1:0] e3_dsq;
  hpt_t                  e3_h [3];
  crd_t                  e3_n [3];

  logic signed [LW:0]      clo [3][3];
  logic signed [XW-LW-1:0] chi [3][3];

  logic                  vld_e4, e4_cand;
  logic signed [PLW-1:0] e4_plo [3][3];
  logic signed [PHW-1:0] e4_phi [3][3];
  logic signed [DSW-1:0] e4_dsq;
  hpt_t                  e4_h [3];

  logic                  vld_e5, e5_cand;
  logic signed [TW-1:0]  e5_t [3][3];
  logic signed [DSW-1:0] e5_dsq;
  hpt_t                  e5_h [3];

  logic signed [SW-1:0]  esum [3];
  logic                  in_tri;

  assign pop = adv && !empty;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      dge[k] = (drem[k] >= RW'(dad[k]));
    end
    for (int i = 0; i < 3; i++) begin
      dseg[i] = DW'(seg_e[i]) - DW'(seg_s[i]);
      ddc[i]  = DW'(h1_prod[i] >>> TFRAC);
    end
    qs = signed'({1'b0, dq[QW]});
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        clo[j][k] = signed'({1'b0, e3_c[j][k][LW-1:0]});
        chi[j][k] = signed'(e3_c[j][k][XW-1:LW]);
      end
      esum[j] = SW'(e5_t[j][0]) + SW'(e5_t[j][1]) + SW'(e5_t[j][2]);
    end
    in_tri = !esum[0][SW-1] && !esum[1][SW-1] && !esum[2][SW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) begin
        dvv[k] <= 1'b0;
      end
      vld_h1    <= 1'b0;
      vld_h2    <= 1'b0;
      vld_e1    <= 1'b0;
      vld_e2    <= 1'b0;
      vld_e3    <= 1'b0;
      vld_e4    <= 1'b0;
      vld_e5    <= 1'b0;
      fin_valid <= 1'b0;
    end else if (adv) begin
      dvv[0] <= !empty;
      for (int k = 0; k < QW; k++) begin
        dvv[k+1] <= dvv[k];
      end
      vld_h1    <= dvv[QW];
      vld_h2    <= vld_h1;
      vld_e1    <= vld_h2;
      vld_e2    <= vld_e1;
      vld_e3    <= vld_e2;
      vld_e4    <= vld_e3;
      vld_e5    <= vld_e4;
      fin_valid <= vld_e5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Load from the queue head.
      dcand[0] <= head.cand;
      drem[0]  <= RW'(head.an);
      dad[0]   <= head.ad;
      dq[0]    <= '0;
      da[0]    <= head.a;
      db[0]    <= head.b;
      dc[0]    <= head.c;
      dn[0]    <= head.n;

      // Restoring division of |num| << 16 by |den|.
      for (int k = 0; k < QW; k++) begin
        dcand[k+1] <= dcand[k];
        drem[k+1]  <= (dge[k] ? drem[k] - RW'(dad[k]) : drem[k]) << 1;
        dad[k+1]   <= dad[k];
        dq[k+1]    <= {dq[k][QW-2:0], dge[k]};
        da[k+1]    <= da[k];
        db[k+1]    <= db[k];
        dc[k+1]    <= dc[k];
        dn[k+1]    <= dn[k];
      end

      // Hit point: H = S + floor(d * t16 / 2^16).
      h1_cand <= dcand[QW];
      h1_a    <= da[QW];
      h1_b    <= db[QW];
      h1_c    <= dc[QW];
      h1_n    <= dn[QW];
      for (int i = 0; i < 3; i++) begin
        h1_prod[i] <= dseg[i] * qs;
      end

      h2_cand <= h1_cand;
      h2_a    <= h1_a;
      h2_b    <= h1_b;
      h2_c    <= h1_c;
      h2_n    <= h1_n;
      for (int i = 0; i < 3; i++) begin
        h2_dd[i] <= ddc[i];
        h2_h[i]  <= HW'(seg_s[i]) + ddc[i];
      end

      // Edge vectors, hit offsets and squared distance terms.
      e1_cand <= h2_cand;
      e1_h    <= h2_h;
      e1_n    <= h2_n;
      for (int i = 0; i < 3; i++) begin
        e1_e[0][i] <= DW'(h2_b[i]) - DW'(h2_a[i]);
        e1_e[1][i] <= DW'(h2_c[i]) - DW'(h2_b[i]);
        e1_e[2][i] <= DW'(h2_a[i]) - DW'(h2_c[i]);
        e1_v[0][i] <= VW'(h2_h[i]) - VW'(h2_a[i]);
        e1_v[1][i] <= VW'(h2_h[i]) - VW'(h2_b[i]);
        e1_v[2][i] <= VW'(h2_h[i]) - VW'(h2_c[i]);
        e1_sq[i]   <= h2_dd[i] * h2_dd[i];
      end

      // Cross product terms.
      e2_cand <= e1_cand;
      e2_h    <= e1_h;
      e2_n    <= e1_n;
      e2_dsq  <= DSW'(e1_sq[0]) + DSW'(e1_sq[1]) + DSW'(e1_sq[2]);
      for (int j = 0; j < 3; j++) begin
        e2_m[j][0] <= e1_e[j][1] * e1_v[j][2];
        e2_m[j][1] <= e1_e[j][2] * e1_v[j][1];
        e2_m[j][2] <= e1_e[j][2] * e1_v[j][0];
        e2_m[j][3] <= e1_e[j][0] * e1_v[j][2];
        e2_m[j][4] <= e1_e[j][0] * e1_v[j][1];
        e2_m[j][5] <= e1_e[j][1] * e1_v[j][0];
      end

      e3_cand <= e2_cand;
      e3_h    <= e2_h;
      e3_n    <= e2_n;
      e3_dsq  <= e2_dsq;
      for (int j = 0; j < 3; j++) begin
        e3_c[j][0] <= XW'(e2_m[j][0]) - XW'(e2_m[j][1]);
        e3_c[j][1] <= XW'(e2_m[j][2]) - XW'(e2_m[j][3]);
        e3_c[j][2] <= XW'(e2_m[j][4]) - XW'(e2_m[j][5]);
      end

      // Normal times cross product, split into two partial products.
      e4_cand <= e3_cand;
      e4_h    <= e3_h;
      e4_dsq  <= e3_dsq;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          e4_plo[j][k] <= e3_n[k] * clo[j][k];
          e4_phi[j][k] <= e3_n[k] * chi[j][k];
        end
      end

      e5_cand <= e4_cand;
      e5_h    <= e4_h;
      e5_dsq  <= e4_dsq;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          e5_t[j][k] <= (TW'(e4_phi[j][k]) <<< LW) + TW'(e4_plo[j][k]);
        end
      end

      fin.hit <= e5_cand && in_tri;
      fin.h   <= e5_h;
      fin.dsq <= e5_dsq;
    end
  end

endmodule

/* rtl/core/sti_sqrt.sv */
module sti_sqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   fin_valid,
  input  sti_pkg::fin_t          fin,
  output logic                   out_valid,
  output logic                   hit,
  output logic [sti_pkg::FW-1:0] hit_x,
  output logic [sti_pkg::FW-1:0] hit_y,
  output logic [sti_pkg::FW-1:0] hit_z,
  output logic [sti_pkg::FW-1:0] hit_distance
);
  import sti_pkg::*;

  logic [DSW+RTW-1:0] ext;

  logic           sv   [SQ_STEPS+1];
  logic           shit [SQ_STEPS+1];
  logic           sbig [SQ_STEPS+1];
  logic [RTW-1:0] sx   [SQ_STEPS+1];
  logic [RTW-1:0] sr   [SQ_STEPS+1];
  hpt_t           sh   [SQ_STEPS+1][3];

  logic [RTW-1:0] bitv [SQ_STEPS];
  logic [RTW-1:0] trial [SQ_STEPS];
  logic           sge  [SQ_STEPS];

  assign ext = (DSW + RTW)'(fin.dsq);

  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv[k]  = RTW'(1) << (RTW - 2 - 2 * k);
      trial[k] = sr[k] + bitv[k];
      sge[k]   = (sx[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sv[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      sv[0] <= fin_valid;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sv[k+1] <= sv[k];
      end
      out_valid <= sv[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      shit[0] <= fin.hit;
      sbig[0] <= |ext[DSW+RTW-1:RTW];
      sx[0]   <= ext[RTW-1:0];
      sr[0]   <= '0;
      sh[0]   <= fin.h;

      // One root bit per stage.
      for (int k = 0; k < SQ_STEPS; k++) begin
        shit[k+1] <= shit[k];
        sbig[k+1] <= sbig[k];
        sh[k+1]   <= sh[k];
        sx[k+1]   <= sge[k] ? sx[k] - trial[k] : sx[k];
        sr[k+1]   <= sge[k] ? (sr[k] >> 1) + bitv[k] : sr[k] >> 1;
      end

      hit   <= shit[SQ_STEPS];
      hit_x <= shit[SQ_STEPS] ? to_field(sh[SQ_STEPS][0]) : '0;
      hit_y <= shit[SQ_STEPS] ? to_field(sh[SQ_STEPS][1]) : '0;
      hit_z <= shit[SQ_STEPS] ? to_field(sh[SQ_STEPS][2]) : '0;
      if (!shit[SQ_STEPS]) begin
        hit_distance <= '0;
      end else if (sbig[SQ_STEPS]) begin
        hit_distance <= '1;
      end else begin
        hit_distance <= sr[SQ_STEPS][FW-1:0];
      end
    end
  end

endmodule

/* rtl/core/segment_triangle_intersect.sv */
// Throughput: one request per cycle when nothing stalls; the 17-stage divider and the
// 32-stage root pipeline each retire one request per cycle while they advance.
// Output stall freezes the back pipeline; the front keeps accepting until the
// 4-entry queue and its own 4 stages fill.
// Reset (rst, synchronous) clears all valid bits, the queue and the segment registers.
module segment_triangle_intersect (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sti_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [sti_pkg::FW-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sti_pkg::FW-1:0]        vertex_a_x,
  input  logic [sti_pkg::FW-1:0]        vertex_a_y,
  input  logic [sti_pkg::FW-1:0]        vertex_a_z,
  input  logic [sti_pkg::FW-1:0]        vertex_b_x,
  input  logic [sti_pkg::FW-1:0]        vertex_b_y,
  input  logic [sti_pkg::FW-1:0]        vertex_b_z,
  input  logic [sti_pkg::FW-1:0]        vertex_c_x,
  input  logic [sti_pkg::FW-1:0]        vertex_c_y,
  input  logic [sti_pkg::FW-1:0]        vertex_c_z,
  input  logic [sti_pkg::FW-1:0]        plane_nx,
  input  logic [sti_pkg::FW-1:0]        plane_ny,
  input  logic [sti_pkg::FW-1:0]        plane_nz,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [sti_pkg::FW-1:0]        hit_x,
  output logic [sti_pkg::FW-1:0]        hit_y,
  output logic [sti_pkg::FW-1:0]        hit_z,
  output logic [sti_pkg::FW-1:0]        hit_distance
);
  import sti_pkg::*;

  // Segment endpoints, raw register bits.
  logic [FW-1:0] seg_start_x;
  logic [FW-1:0] seg_start_y;
  logic [FW-1:0] seg_start_z;
  logic [FW-1:0] seg_end_x;
  logic [FW-1:0] seg_end_y;
  logic [FW-1:0] seg_end_z;

  crd_t seg_s [3];
  crd_t seg_e [3];

  // Front to queue to back.
  logic push;
  tri_t push_data;
  logic full;
  logic pop;
  tri_t head;
  logic empty;

  // Back to root stage.
  logic fin_valid;
  fin_t fin;

  // Back half advances unless a finished result is held by the consumer.
  logic adv;

  assign adv = !(out_valid && out_stall);

  assign seg_s[0] = coord(seg_start_x);
  assign seg_s[1] = coord(seg_start_y);
  assign seg_s[2] = coord(seg_start_z);
  assign seg_e[0] = coord(seg_end_x);
  assign seg_e[1] = coord(seg_end_y);
  assign seg_e[2] = coord(seg_end_z);

  // Register writes; indexes past the map are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start_x <= '0;
      seg_start_y <= '0;
      seg_start_z <= '0;
      seg_end_x   <= '0;
      seg_end_y   <= '0;
      seg_end_z   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEG_START_X: seg_start_x <= cfg_data;
        REG_SEG_START_Y: seg_start_y <= cfg_data;
        REG_SEG_START_Z: seg_start_z <= cfg_data;
        REG_SEG_END_X:   seg_end_x   <= cfg_data;
        REG_SEG_END_Y:   seg_end_y   <= cfg_data;
        REG_SEG_END_Z:   seg_end_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: plane dot products and the 0 <= t <= 1 test.
  sti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .vertex_a_x (vertex_a_x),
    .vertex_a_y (vertex_a_y),
    .vertex_a_z (vertex_a_z),
    .vertex_b_x (vertex_b_x),
    .vertex_b_y (vertex_b_y),
    .vertex_b_z (vertex_b_z),
    .vertex_c_x (vertex_c_x),
    .vertex_c_y (vertex_c_y),
    .vertex_c_z (vertex_c_z),
    .plane_nx   (plane_nx),
    .plane_ny   (plane_ny),
    .plane_nz   (plane_nz),
    .seg_s      (seg_s),
    .seg_e      (seg_e),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  // Queue that decouples front and back stalls.
  sti_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // Back: divide for t, form the hit point, run an edge test on each triangle edge.
  sti_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .seg_s     (seg_s),
    .seg_e     (seg_e),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  // Distance root and output register.
  sti_sqrt u_sqrt (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .fin_valid    (fin_valid),
    .fin          (fin),
    .out_valid    (out_valid),
    .hit          (hit),
    .hit_x        (hit_x),
    .hit_y        (hit_y),
    .hit_z        (hit_z),
    .hit_distance (hit_distance)
  );

endmodule

/* tb/sv/segment_triangle_intersect_tb.sv */
`timescale 1ns / 1ps

module segment_triangle_intersect_tb;
  import sti_pkg::*;

  typedef logic signed [255:0] wide_t;

  // One triangle request: vertices and plane normal, x/y/z per packed lane.
  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0][31:0] c;
    logic [2:0][31:0] n;
  } tri_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] span;
  } hit_res_t;

  localparam int TIMEOUT_CYCLES = 500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tri_req_t    req_bus = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [31:0] hit_x, hit_y, hit_z, hit_distance;

  // Segment registers as the block should hold them.
  logic [5:0][31:0] seg_regs = '0;

  tri_req_t    pending_tris[$];
  hit_res_t    expected_hits[$];
  bit          took = 1'b0;
  bit          calm = 1'b0;
  bit          choke_req = 1'b0;
  bit          choke_done = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          choke_cnt = 0;
  int          errs = 0;
  int          cycles = 0;

  segment_triangle_intersect i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall,
    .vertex_a_x(req_bus.a[0]), .vertex_a_y(req_bus.a[1]), .vertex_a_z(req_bus.a[2]),
    .vertex_b_x(req_bus.b[0]), .vertex_b_y(req_bus.b[1]), .vertex_b_z(req_bus.b[2]),
    .vertex_c_x(req_bus.c[0]), .vertex_c_y(req_bus.c[1]), .vertex_c_z(req_bus.c[2]),
    .plane_nx(req_bus.n[0]), .plane_ny(req_bus.n[1]), .plane_nz(req_bus.n[2]),
    .out_valid, .out_stall,
    .hit, .hit_x, .hit_y, .hit_z, .hit_distance
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t mulw(input wide_t x, input wide_t y);
    return x * y;
  endfunction

  // N . ((q - p) x (h - p)), exact.
  function automatic wide_t edge_side(input longint n[3], input longint p[3],
                                      input longint q[3], input longint h[3]);
    longint e[3], v[3];
    wide_t c0, c1, c2;
    for (int i = 0; i < 3; i++) begin
      e[i] = q[i] - p[i];
      v[i] = h[i] - p[i];
    end
    c0 = mulw(e[1], v[2]) - mulw(e[2], v[1]);
    c1 = mulw(e[2], v[0]) - mulw(e[0], v[2]);
    c2 = mulw(e[0], v[1]) - mulw(e[1], v[0]);
    return mulw(n[0], c0) + mulw(n[1], c1) + mulw(n[2], c2);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Expected result of one triangle against the programmed segment.
  function automatic hit_res_t solve_hit(input tri_req_t r, input logic [5:0][31:0] seg);
    hit_res_t res;
    longint s[3], e[3], d[3], a[3], b[3], c[3], n[3], h[3], q, dd;
    wide_t num, den, an, ad, dsq;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'($signed(seg[i]));
      e[i] = longint'($signed(seg[3 + i]));
      a[i] = longint'($signed(r.a[i]));
      b[i] = longint'($signed(r.b[i]));
      c[i] = longint'($signed(r.c[i]));
      n[i] = longint'($signed(r.n[i]));
      d[i] = e[i] - s[i];
    end
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      num = num + mulw(n[i], a[i]) - mulw(n[i], s[i]);
      den = den + mulw(n[i], d[i]);
    end
    // Parallel segment or crossing outside 0..1: no hit.
    if (den == 0) return res;
    if (den < 0) begin
      if (!(den <= num && num <= 0)) return res;
    end else begin
      if (!(num >= 0 && num <= den)) return res;
    end
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = longint'((an <<< 16) / ad);
    for (int i = 0; i < 3; i++) h[i] = s[i] + ((d[i] * q) >>> 16);
    // Points on an edge count as inside.
    if (edge_side(n, a, b, h) < 0 || edge_side(n, b, c, h) < 0 || edge_side(n, c, a, h) < 0)
      return res;
    dsq = 0;
    for (int i = 0; i < 3; i++) begin
      dd = h[i] - s[i];
      dsq = dsq + mulw(dd, dd);
    end
    res.hit = 1'b1;
    res.x = h[0][31:0];
    res.y = h[1][31:0];
    res.z = h[2][31:0];
    res.span = (dsq[255:64] != 0) ? 32'hFFFF_FFFF : 32'(root_floor(dsq[63:0]));
    return res;
  endfunction

  function automatic longint rnd_off(input int bits);
    return longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
  endfunction

  // Triangle centered on a point of the segment, so the crossing usually lands inside.
  function automatic tri_req_t aim_tri(input logic [5:0][31:0] seg);
    tri_req_t r;
    longint p[3], u[3], v[3], ab[3], ac[3], cr[3], lim;
    int t, sz;
    bit big;
    t = $urandom_range(0, 65536);
    if ($urandom_range(0, 5) == 0) t = $urandom_range(0, 1) ? 0 : 65536;
    sz = $urandom_range(2, 18);
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(seg[i])) +
             (((longint'($signed(seg[3 + i])) - longint'($signed(seg[i]))) * t) >>> 16);
      u[i] = rnd_off(sz);
      v[i] = rnd_off(sz);
      ab[i] = v[i] - u[i];
      ac[i] = -2 * u[i] - v[i];
    end
    cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
    cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
    cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
    lim = longint'(1) << 30;
    big = 1'b1;
    while (big) begin
      big = 1'b0;
      for (int i = 0; i < 3; i++) if (cr[i] >= lim || cr[i] <= -lim) big = 1'b1;
      if (big) for (int i = 0; i < 3; i++) cr[i] = cr[i] >>> 1;
    end
    // Flip the normal now and then: wrong winding must miss.
    if ($urandom_range(0, 5) == 0) for (int i = 0; i < 3; i++) cr[i] = -cr[i];
    for (int i = 0; i < 3; i++) begin
      r.a[i] = 32'(p[i] + u[i]);
      r.b[i] = 32'(p[i] + v[i]);
      r.c[i] = 32'(p[i] - u[i] - v[i]);
      r.n[i] = 32'(cr[i]);
    end
    return r;
  endfunction

  function automatic tri_req_t noise_tri();
    tri_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.a[i] = $urandom;
      r.b[i] = $urandom;
      r.c[i] = $urandom;
      r.n[i] = $urandom;
    end
    return r;
  endfunction

  function automatic tri_req_t flat_tri(input longint ax, ay, bx, by, cx, cy, z, nz);
    tri_req_t r;
    r.a = {32'(z), 32'(ay), 32'(ax)};
    r.b = {32'(z), 32'(by), 32'(bx)};
    r.c = {32'(z), 32'(cy), 32'(cx)};
    r.n = {32'(nz), 32'd0, 32'd0};
    return r;
  endfunction

  // Drive the request channel: hold a stalled request, else idle or advance.
  always @(negedge clk) begin
    if (in_valid && !took) begin
      // hold
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_tris.size() > 0) begin
      in_valid <= 1'b1;
      req_bus <= pending_tris.pop_front();
      if (!calm && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 13);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Drive the result stall: one long hold-off on request, else short bursts.
  always @(negedge clk) begin
    if (choke_req && !choke_done) begin
      choke_done <= 1'b1;
      choke_cnt <= 400;
      out_stall <= 1'b1;
    end else if (choke_cnt > 0) begin
      choke_cnt <= choke_cnt - 1;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    hit_res_t want;
    cycles <= cycles + 1;
    took <= in_valid && !in_stall;
    if (cfg_we) seg_regs[cfg_index] <= cfg_data;
    if (!rst && in_valid && !in_stall) expected_hits.push_back(solve_hit(req_bus, seg_regs));
    if (!rst && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        $error("result with no request pending");
        errs <= errs + 1;
      end else begin
        want = expected_hits.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d actual %0d", want.hit, hit);
          errs <= errs + 1;
        end
        if (hit_x !== want.x) begin
          $error("hit_x: expected %h actual %h", want.x, hit_x);
          errs <= errs + 1;
        end
        if (hit_y !== want.y) begin
          $error("hit_y: expected %h actual %h", want.y, hit_y);
          errs <= errs + 1;
        end
        if (hit_z !== want.z) begin
          $error("hit_z: expected %h actual %h", want.z, hit_z);
          errs <= errs + 1;
        end
        if (hit_distance !== want.span) begin
          $error("hit_distance: expected %h actual %h", want.span, hit_distance);
          errs <= errs + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > TIMEOUT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic load_segment(input logic [5:0][31:0] seg);
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_IW'(i);
      cfg_data <= seg[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every request to drain, then let the pipeline settle.
  task automatic drain();
    while (pending_tris.size() > 0 || in_valid || expected_hits.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    logic [5:0][31:0] seg;
    localparam longint ONE = 65536;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: segment along z from -2 to +2.
    seg = '0;
    seg[REG_SEG_START_Z] = 32'(-2 * ONE);
    seg[REG_SEG_END_Z] = 32'(2 * ONE);
    load_segment(seg);
    pending_tris.push_back(flat_tri(-ONE, -ONE, ONE, -ONE, 0, ONE, 0, ONE));      // center hit
    pending_tris.push_back(flat_tri(-ONE, -ONE, 0, ONE, ONE, -ONE, 0, -ONE));     // negative den
    pending_tris.push_back(flat_tri(-ONE, -ONE, ONE, -ONE, 0, ONE, -2 * ONE, ONE)); // t = 0
    pending_tris.push_back(flat_tri(-ONE, -ONE, ONE, -ONE, 0, ONE, 2 * ONE, ONE));  // t = 1
    pending_tris.push_back(flat_tri(-ONE, -ONE, ONE, -ONE, 0, ONE, 3 * ONE, ONE));  // past end
    pending_tris.push_back(flat_tri(0, 0, ONE, 0, 0, ONE, 0, ONE));               // on a vertex
    pending_tris.push_back(flat_tri(-ONE, 0, ONE, 0, 0, ONE, 0, ONE));            // on an edge
    pending_tris.push_back(flat_tri(ONE, ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE)); // outside
    pending_tris.push_back(flat_tri(0, 0, 0, 0, 0, 0, 0, ONE));                   // degenerate
    pending_tris.push_back(flat_tri(-ONE, -ONE, ONE, -ONE, 0, ONE, 0, 0));        // zero normal
    pending_tris.push_back('0);
    pending_tris.push_back({12{32'h7FFF_FFFF}});
    pending_tris.push_back({12{32'h8000_0000}});
    pending_tris.push_back({6{64'h5555_5555_AAAA_AAAA}});
    pending_tris.push_back({6{64'hAAAA_AAAA_5555_5555}});
    pending_tris.push_back({12{32'hFFFF_FFFF}});
    begin
      tri_req_t par;
      par = flat_tri(-ONE, -ONE, ONE, -ONE, 0, ONE, 0, 0);
      par.n[0] = 32'(ONE);                                                         // parallel
      pending_tris.push_back(par);
    end
    drain();

    // Random phases over several segments, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        2: seg = {{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}};
        4: begin
          for (int i = 0; i < 3; i++) seg[i] = 32'(rnd_off(21));
          for (int i = 0; i < 3; i++) seg[3 + i] = seg[i];                        // zero length
        end
        default: for (int i = 0; i < 6; i++) seg[i] = 32'(rnd_off(21));
      endcase
      load_segment(seg);
      for (int k = 0; k < 115; k++) begin
        case ($urandom_range(0, 9))
          0: pending_tris.push_back(noise_tri());
          1: begin
            tri_req_t t;
            t = aim_tri(seg);
            t.n[$urandom_range(0, 2)] = $urandom;
            pending_tris.push_back(t);
          end
          default: pending_tris.push_back(aim_tri(seg));
        endcase
      end
      if (ph == 1) choke_req = 1'b1;
      if (ph == 5) begin
        while (pending_tris.size() > 100) @(posedge clk);
        calm = 1'b1;
      end
      drain();
    end

    if (errs == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
